>>> sv/nwbs_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none

package nwbs_pkg;

    // Window geometry
    localparam int PATTERN_BYTES = 8;
    localparam int POSITION_BITS = 32;
    localparam int PB_W          = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    // Register and field widths
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LEN_W      = 4;
    localparam int OCC_W      = 32;
    localparam int ADDR_W     = 64;
    localparam int COUNT_W    = 32;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_REPORT    = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_NIBBLES   = 3'd0,
        CFG_PATTERN_CARE      = 3'd1,
        CFG_PATTERN_LENGTH    = 3'd2,
        CFG_WANTED_OCCURRENCE = 3'd3,
        CFG_BASE_ADDRESS      = 3'd4,
        CFG_RESULT_OFFSET     = 3'd5,
        CFG_REPORT_EACH       = 3'd6
    } t_cfg_idx;

    // Per-cell control from the scan controller
    typedef struct packed {
        logic shift;  // take the neighbor's byte
        logic clear;  // drop window contents (end of buffer)
        logic used;   // cell lies inside the active pattern length
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> sv/nwbs_in_if.sv
// Input channel: one buffer byte per item with its last-byte mark.
`default_nettype none

interface nwbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> sv/nwbs_out_if.sv
// Output channel: one scan result per item.
`default_nettype none

interface nwbs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [63:0] match_address;
    logic [31:0] matches_seen;
    logic        run_end;

    modport source (output valid, output result_kind, output match_address,
                    output matches_seen, output run_end, input ready);
    modport sink   (input valid, input result_kind, input match_address,
                    input matches_seen, input run_end, output ready);
endinterface

`default_nettype wire

>>> sv/nwbs_cell.sv
// One window cell: holds a byte, passes it on, and checks the incoming byte.
`default_nettype none

module nwbs_cell
    import nwbs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic [7:0] i_byte,
    input  wire logic      i_valid,
    input  wire logic [7:0] i_pat,
    input  wire logic [1:0] i_care,
    output logic [7:0]     o_byte,
    output logic           o_valid,
    output logic           o_hit
);

    logic [7:0] r_byte;
    logic       r_valid;
    logic       hi_ok;
    logic       lo_ok;

    // Nibble compare on the byte this cell takes in; care bit 1 is the high nibble
    always_comb begin
        hi_ok = !i_care[1] || (i_pat[7:4] == i_byte[7:4]);
        lo_ok = !i_care[0] || (i_pat[3:0] == i_byte[3:0]);
        o_hit = !i_ctl.used || (i_valid && hi_ok && lo_ok);
    end

    // Window byte and its fill mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> sv/nibble_wildcard_byte_pattern_scanner_core.sv
// Top level of the wildcard byte pattern scanner: cell chain, scan control, result stage.
`default_nettype none

// Takes one buffer byte per cycle when input ready allows and compares the newest
// bytes against a pattern of up to eight bytes with per-nibble wildcards, held in
// a chain of eight cells that shift the window by one byte per item. The compare,
// match count and decision all settle in the cycle a byte is accepted; a result
// passes through the record stage and then the output register. The input runs at
// one byte per cycle as long as results are taken; a byte that causes two results
// (a report and the final result) holds the record stage until both are handed to
// the output. Input ready follows the output handshake through the record stage.
// Configuration must be written only between buffers by the user; the block does
// not enforce it. Base plus offset is summed into a register in the cycle after.
module nibble_wildcard_byte_pattern_scanner_core
    import nwbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    nwbs_in_if.sink                    i_in,
    nwbs_out_if.source                 o_out
);

    // Configuration registers
    logic [63:0]              r_nibbles;
    logic [63:0]              r_care;
    logic [LEN_W-1:0]         r_len;
    logic signed [OCC_W-1:0]  r_occ;
    logic [ADDR_W-1:0]        r_base;
    logic [ADDR_W-1:0]        r_off;
    logic                     r_report;
    logic [ADDR_W-1:0]        r_base_off;

    // Scan state
    logic [POSITION_BITS-1:0] r_pos;
    logic [COUNT_W-1:0]       r_total;
    logic                     r_finished;

    // Record stage
    logic                     r_p_vld;
    logic                     r_p_idx;
    logic                     r_p_two;
    t_kind                    r_p_kind0;
    t_kind                    r_p_kind1;
    logic [COUNT_W-1:0]       r_p_tot0;
    logic [COUNT_W-1:0]       r_p_tot1;
    logic [POSITION_BITS-1:0] r_p_start;

    // Output register
    logic                     r_o_vld;
    t_kind                    r_o_kind;
    logic [ADDR_W-1:0]        r_o_addr;
    logic [COUNT_W-1:0]       r_o_seen;
    logic                     r_o_end;

    // Cell chain
    logic [7:0]               cell_byte [PATTERN_BYTES];
    logic                     cell_valid[PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] cell_hit;
    t_cell_ctl                cell_ctl  [PATTERN_BYTES];

    logic [LEN_W-1:0]         len_c;
    logic                     acc;
    logic                     live;
    logic                     match;
    logic                     occ_hit;
    logic                     found;
    logic                     report;
    logic                     not_found;
    logic                     have;
    logic                     total_inc;
    logic [COUNT_W-1:0]       total_after;
    logic [POSITION_BITS-1:0] start;
    logic                     out_load;
    logic                     p_last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nibbles <= '0;
            r_care    <= '0;
            r_len     <= '0;
            r_occ     <= '0;
            r_base    <= '0;
            r_off     <= '0;
            r_report  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PATTERN_NIBBLES:   r_nibbles <= i_cfg_data;
                CFG_PATTERN_CARE:      r_care    <= i_cfg_data;
                CFG_PATTERN_LENGTH:    r_len     <= i_cfg_data[LEN_W-1:0];
                CFG_WANTED_OCCURRENCE: r_occ     <= i_cfg_data[OCC_W-1:0];
                CFG_BASE_ADDRESS:      r_base    <= i_cfg_data;
                CFG_RESULT_OFFSET:     r_off     <= i_cfg_data;
                CFG_REPORT_EACH:       r_report  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Base and offset folded into one addend
    always_ff @(posedge i_clk) begin
        r_base_off <= r_base + r_off;
    end

    // Active length, clamped to the window
    assign len_c = (r_len > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES) : r_len;

    assign acc  = i_in.valid && i_in.ready;
    assign live = acc && !r_finished;

    // Cells: cell i checks the i-th newest byte (0 is the incoming one) against pattern byte len-1-i
    for (genvar i = 0; i < PATTERN_BYTES; i++) begin : g_cell
        logic [PB_W-1:0] pidx;
        logic [7:0]      in_byte;
        logic            in_valid;

        assign pidx = PB_W'(len_c - LEN_W'(1) - LEN_W'(i));

        if (i == 0) begin : g_head
            assign in_byte  = i_in.data_byte;
            assign in_valid = 1'b1;
        end else begin : g_link
            assign in_byte  = cell_byte[i-1];
            assign in_valid = cell_valid[i-1];
        end

        assign cell_ctl[i].shift = live;
        assign cell_ctl[i].clear = acc && i_in.last_byte;
        assign cell_ctl[i].used  = LEN_W'(i) < len_c;

        nwbs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[i]),
            .i_byte  (in_byte),
            .i_valid (in_valid),
            .i_pat   (r_nibbles[8*pidx +: 8]),
            .i_care  (r_care[2*pidx +: 2]),
            .o_byte  (cell_byte[i]),
            .o_valid (cell_valid[i]),
            .o_hit   (cell_hit[i])
        );
    end

    // Match decision for the accepted byte
    always_comb begin
        match       = (len_c != '0) && (&cell_hit);
        occ_hit     = (r_occ == '0) ||
                      (!r_occ[OCC_W-1] && (COUNT_W'(r_occ) == r_total));
        found       = live && match && occ_hit;
        report      = live && match && r_report;
        not_found   = live && i_in.last_byte && !found;
        have        = report || found || not_found;
        total_inc   = live && match && !occ_hit && (r_total != '1);
        total_after = r_total + COUNT_W'(total_inc);
        start       = r_pos - POSITION_BITS'(len_c - LEN_W'(1));
    end

    // Position, count and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_total    <= '0;
            r_finished <= 1'b0;
        end else if (acc) begin
            if (i_in.last_byte) begin
                r_pos      <= '0;
                r_total    <= '0;
                r_finished <= 1'b0;
            end else if (live) begin
                if (r_pos != '1) begin
                    r_pos <= r_pos + POSITION_BITS'(1);
                end
                r_total <= total_after;
                if (found) begin
                    r_finished <= 1'b1;
                end
            end
        end
    end

    // Record stage hands its results to the output one at a time
    assign out_load   = r_p_vld && (!r_o_vld || o_out.ready);
    assign p_last     = !r_p_two || r_p_idx;
    assign i_in.ready = !r_p_vld || (out_load && p_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_p_idx <= 1'b0;
        end else if (acc && have) begin
            r_p_vld <= 1'b1;
            r_p_idx <= 1'b0;
        end else if (out_load) begin
            if (p_last) begin
                r_p_vld <= 1'b0;
            end else begin
                r_p_idx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && have) begin
            r_p_two   <= report && (found || not_found);
            r_p_start <= start;
            if (report) begin
                r_p_kind0 <= KIND_REPORT;
                r_p_tot0  <= r_total;
                r_p_kind1 <= found ? KIND_FOUND : KIND_NOT_FOUND;
                r_p_tot1  <= found ? r_total : total_after;
            end else begin
                r_p_kind0 <= found ? KIND_FOUND : KIND_NOT_FOUND;
                r_p_tot0  <= found ? r_total : total_after;
                r_p_kind1 <= KIND_NOT_FOUND;
                r_p_tot1  <= total_after;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_load) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_kind <= r_p_idx ? r_p_kind1 : r_p_kind0;
            r_o_seen <= r_p_idx ? r_p_tot1 : r_p_tot0;
            r_o_end  <= p_last;
            if ((r_p_idx ? r_p_kind1 : r_p_kind0) == KIND_NOT_FOUND) begin
                r_o_addr <= '0;
            end else begin
                r_o_addr <= r_base_off + ADDR_W'(r_p_start);
            end
        end
    end

    assign o_out.valid         = r_o_vld;
    assign o_out.result_kind   = r_o_kind;
    assign o_out.match_address = r_o_addr;
    assign o_out.matches_seen  = r_o_seen;
    assign o_out.run_end       = r_o_end;

endmodule

`default_nettype wire

>>> tb/nwbs_scan_checker.sv
// Scoreboard for the pattern scanner: predicts the results of each input byte and compares them.
`timescale 1ns / 1ps

module nwbs_scan_checker
    import nwbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    nwbs_in_if                         i_in,
    nwbs_out_if                        i_out,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  seen;
        logic                run_end;
    } t_scan_result;

    // Shadow copy of the configuration registers
    logic [CFG_DATA_W-1:0]    pat_nibbles;
    logic [CFG_DATA_W-1:0]    pat_care;
    logic [LEN_W-1:0]         pat_len;
    logic signed [OCC_W-1:0]  occ_wanted;
    logic [ADDR_W-1:0]        base_addr;
    logic [ADDR_W-1:0]        addr_offset;
    logic                     report_all;

    // Shadow scan state
    logic [7:0]               window_q [PATTERN_BYTES];
    int unsigned              window_count;
    logic [POSITION_BITS-1:0] scan_pos;
    logic [COUNT_W-1:0]       hit_count;
    logic                     scan_done;

    t_scan_result pending_results [$];
    int           fail_total = 0;

    task automatic clear_scan();
        for (int i = 0; i < PATTERN_BYTES; i++) window_q[i] = 8'h00;
        window_count = 0;
        scan_pos     = '0;
        hit_count    = '0;
        scan_done    = 1'b0;
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (t_cfg_idx'(idx))
            CFG_PATTERN_NIBBLES:   pat_nibbles = d;
            CFG_PATTERN_CARE:      pat_care    = d;
            CFG_PATTERN_LENGTH:    pat_len     = d[LEN_W-1:0];
            CFG_WANTED_OCCURRENCE: occ_wanted  = d[OCC_W-1:0];
            CFG_BASE_ADDRESS:      base_addr   = d;
            CFG_RESULT_OFFSET:     addr_offset = d;
            CFG_REPORT_EACH:       report_all  = d[0];
            default: ;
        endcase
    endtask

    // Nibble compare: care bit k guards pattern nibble k
    function automatic logic nibble_hit(input logic [3:0] data_nib, input int k);
        if (!pat_care[k]) return 1'b1;
        return pat_nibbles[4*k +: 4] == data_nib;
    endfunction

    // Shift one byte into the window and queue up whatever it causes
    task automatic predict_scan(input logic [7:0] din, input logic last);
        int unsigned        len;
        int                 n;
        logic               hit;
        logic [7:0]         b;
        logic [ADDR_W-1:0]  start;
        logic [ADDR_W-1:0]  addr;
        t_scan_result       res [2];

        len = (pat_len > PATTERN_BYTES) ? PATTERN_BYTES : pat_len;
        n   = 0;

        // after a found result everything up to the last-byte mark is dropped
        if (scan_done) begin
            if (last) clear_scan();
            return;
        end

        for (int i = PATTERN_BYTES - 1; i > 0; i--) window_q[i] = window_q[i-1];
        window_q[0] = din;
        if (window_count < PATTERN_BYTES) window_count++;

        hit = (len > 0) && (window_count >= len);
        for (int j = 0; j < len; j++) begin
            b = window_q[len - 1 - j];
            if (!nibble_hit(b[7:4], 2*j + 1) || !nibble_hit(b[3:0], 2*j)) hit = 1'b0;
        end

        if (hit) begin
            start = ADDR_W'(scan_pos) - ADDR_W'(len - 1);
            addr  = base_addr + start + addr_offset;
            if (report_all) begin
                res[n].kind = KIND_REPORT;
                res[n].addr = addr;
                res[n].seen = hit_count;
                res[n].run_end = 1'b0;
                n++;
            end
            if (occ_wanted == 0 || (occ_wanted > 0 && $unsigned(occ_wanted) == hit_count)) begin
                res[n].kind = KIND_FOUND;
                res[n].addr = addr;
                res[n].seen = hit_count;
                res[n].run_end = 1'b0;
                n++;
                scan_done = 1'b1;
            end else if (hit_count != '1) begin
                hit_count++;
            end
        end

        if (scan_pos != '1) scan_pos++;

        if (last) begin
            if (!scan_done) begin
                res[n].kind = KIND_NOT_FOUND;
                res[n].addr = '0;
                res[n].seen = hit_count;
                res[n].run_end = 1'b0;
                n++;
            end
            clear_scan();
        end

        if (n > 0) res[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++) pending_results = {pending_results, res[i]};
    endtask

    task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_result();
        t_scan_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual kind %0d addr %h count %0d end %0b",
                     $time, i_out.result_kind, i_out.match_address, i_out.matches_seen,
                     i_out.run_end);
            fail_total++;
        end else begin
            want = pending_results.pop_front();
            compare_field("result_kind", 64'(want.kind), 64'(i_out.result_kind));
            compare_field("match_address", want.addr, i_out.match_address);
            compare_field("matches_seen", 64'(want.seen), 64'(i_out.matches_seen));
            compare_field("run_end", 64'(want.run_end), 64'(i_out.run_end));
        end
    endtask

    // Sample both channels and the config port on every rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_nibbles = '0;
            pat_care    = '0;
            pat_len     = '0;
            occ_wanted  = '0;
            base_addr   = '0;
            addr_offset = '0;
            report_all  = 1'b0;
            clear_scan();
            pending_results.delete();
        end else begin
            if (i_cfg_we) apply_config(i_cfg_idx, i_cfg_data);
            if (i_out.valid && i_out.ready) check_result();
            if (i_in.valid && i_in.ready) predict_scan(i_in.data_byte, i_in.last_byte);
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_results.size();
    end

endmodule

>>> tb/nibble_wildcard_byte_pattern_scanner_core_tb.sv
// Testbench top for the pattern scanner: clock, reset, configuration, byte stimulus and verdict.
`timescale 1ns / 1ps

module nibble_wildcard_byte_pattern_scanner_core_tb;
    import nwbs_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;

    nwbs_in_if  in_ch ();
    nwbs_out_if out_ch ();

    nibble_wildcard_byte_pattern_scanner_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    nwbs_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stimulus-side copy of the pattern, used to plant matches in buffers
    logic [63:0] cur_nibbles;
    logic [63:0] cur_care;
    int unsigned cur_len;
    logic        quiet;
    int          items_sent;
    logic [7:0]  buffer_bytes [$];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones; none in quiet phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Output back-pressure
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
                if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap();
            end
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = d;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic program_scanner(input logic [63:0] nib, input logic [63:0] care,
                                   input logic [3:0] len, input logic [31:0] occ,
                                   input logic [63:0] base, input logic [63:0] off,
                                   input logic rep);
        cfg_write(CFG_PATTERN_NIBBLES, nib);
        cfg_write(CFG_PATTERN_CARE, care);
        cfg_write(CFG_PATTERN_LENGTH, 64'(len));
        cfg_write(CFG_WANTED_OCCURRENCE, {$urandom, occ});
        cfg_write(CFG_BASE_ADDRESS, base);
        cfg_write(CFG_RESULT_OFFSET, off);
        cfg_write(CFG_REPORT_EACH, {63'(rand64()), rep});
        cur_nibbles = nib;
        cur_care    = care;
        cur_len     = (len > PATTERN_BYTES) ? PATTERN_BYTES : len;
        // base plus offset lands in a register in the cycle after the write
        repeat (2) @(negedge i_clk);
    endtask

    // One byte on the input channel, held until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        in_ch.last_byte = last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buffer_bytes.size(); i++)
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
        buffer_bytes.delete();
    endtask

    // Drain results and let the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic random_config();
        int          r;
        logic [3:0]  len;
        logic [31:0] occ;
        logic [63:0] base;
        logic [63:0] off;
        logic [63:0] care;

        r = $urandom_range(0, 99);
        if (r < 10)      len = 4'd0;
        else if (r < 70) len = 4'($urandom_range(1, 3));
        else if (r < 85) len = 4'($urandom_range(4, 7));
        else if (r < 92) len = 4'd8;
        else             len = 4'($urandom_range(9, 15));

        r = $urandom_range(0, 99);
        if (r < 30)      occ = 32'hFFFF_FFFF;
        else if (r < 50) occ = 32'd0;
        else if (r < 80) occ = $urandom_range(1, 5);
        else if (r < 85) occ = 32'h7FFF_FFFF;
        else if (r < 92) occ = 32'h8000_0000 | ($urandom & 32'h7FFF_FFFE);
        else             occ = $urandom_range(6, 40);

        r = $urandom_range(0, 99);
        if (r < 10)      base = '1;
        else if (r < 20) base = '0;
        else             base = rand64();
        r = $urandom_range(0, 99);
        if (r < 10)      off = '1;
        else if (r < 20) off = '0;
        else             off = rand64();

        r = $urandom_range(0, 99);
        if (r < 10)      care = '1;
        else if (r < 20) care = '0;
        else             care = rand64() & rand64();

        program_scanner(rand64(), care, len, occ, base, off, 1'($urandom));
    endtask

    // Random buffer, mostly with planted pattern copies
    task automatic build_buffer(input logic noise);
        int         target;
        logic [7:0] b;
        target = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 60);
        while (buffer_bytes.size() < target) begin
            if (!noise && cur_len > 0 && $urandom_range(0, 99) < 35) begin
                for (int j = 0; j < cur_len; j++) begin
                    b = 8'($urandom);
                    if (cur_care[2*j+1]) b[7:4] = cur_nibbles[8*j+4 +: 4];
                    if (cur_care[2*j])   b[3:0] = cur_nibbles[8*j +: 4];
                    buffer_bytes = {buffer_bytes, b};
                end
            end else if (buffer_bytes.size() > 0 && $urandom_range(0, 99) < 10) begin
                buffer_bytes = {buffer_bytes, buffer_bytes[$]};
            end else begin
                buffer_bytes = {buffer_bytes, 8'($urandom)};
            end
        end
    endtask

    initial begin
        int buffers;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        quiet           = 1'b0;
        items_sent      = 0;
        cur_nibbles     = '0;
        cur_care        = '0;
        cur_len         = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty pattern straight out of reset: not found, count zero
        buffer_bytes = '{8'h00, 8'hFF};
        send_buffer();
        wait_idle();

        // Exact two-byte pattern, scan all, report each, address wraps
        program_scanner(64'hCDAB, 64'hFFFF, 4'd2, 32'hFFFF_FFFF, '1, 64'h1, 1'b1);
        buffer_bytes = '{8'hAB, 8'hCD, 8'hAB, 8'hCD};
        send_buffer();
        wait_idle();

        // All-wildcard pattern, first match ends the scan, later bytes ignored
        program_scanner(64'h0, 64'h0, 4'd2, 32'd0, 64'h1000, 64'h0, 1'b0);
        buffer_bytes = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
        send_buffer();
        wait_idle();

        // High nibble only, wanted occurrence lands on the last byte
        program_scanner(64'hF0, 64'h2, 4'd1, 32'd2, 64'h0, '1, 1'b1);
        buffer_bytes = '{8'hF1, 8'hF2, 8'hF3};
        send_buffer();
        wait_idle();

        // Length beyond the window, negative occurrence scans everything
        program_scanner(64'h0123_4567_89AB_CDEF, '1, 4'd15, 32'h8000_0000, 64'h0, 64'h0, 1'b0);
        buffer_bytes = '{8'hEF, 8'hCD, 8'hAB, 8'h89, 8'h67, 8'h45, 8'h23, 8'h01, 8'h00};
        send_buffer();
        wait_idle();

        // Random phases: new settings, then a handful of buffers
        while (items_sent < 1250) begin
            quiet = ($urandom_range(0, 99) < 20);
            random_config();
            buffers = $urandom_range(3, 8);
            repeat (buffers) begin
                build_buffer($urandom_range(0, 99) < 15);
                send_buffer();
            end
            wait_idle();
        end

        quiet = 1'b0;
        wait_idle();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
